@@ hdl/bba_pkg.sv @@
// types, codes and default constants of the buddy block allocator
// used by bba_ctrl, bba_dp and buddy_block_allocator; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

	localparam int NUM_UNITS_DEF  = 256;
	localparam int UNIT_SHIFT_DEF = 20;
	localparam int MAX_ORDER      = 15;

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [1:0] REG_BASE_ADDR = 2'd0;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] request_length;
		logic [7:0]  block_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  result_index;
		logic [31:0] start_address;
		logic [31:0] block_bytes;
	} rsp_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLR,
		OP_LOAD,
		OP_ORD_STEP,
		OP_RD_CUR,
		OP_SCAN_EV,
		OP_SPLIT,
		OP_ALLOC_WR,
		OP_WALK_EV,
		OP_FREE_CLR,
		OP_RD_BUDDY,
		OP_MERGE_WR1,
		OP_MERGE_WR2,
		OP_RESULT
	} op_t;

	typedef enum logic [1:0] {
		RES_OK_ADDR,
		RES_OK_FREE,
		RES_NOFIT,
		RES_RANGE
	} res_t;

	typedef struct packed {
		op_t  op;
		res_t res;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_alloc;
		logic is_free;
		logic len_zero;
		logic m_big;
		logic m_zero;
		logic bidx_range;
		logic scan_exact;
		logic scan_last;
		logic found_next;
		logic hit;
		logic past;
		logic split_more;
		logic merge_stop;
		logic merge_ok;
		logic out_free;
	} flags_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISP,
		S_ORDER,
		S_SCAN_RD,
		S_SCAN_EV,
		S_SPLIT,
		S_WALK_RD,
		S_WALK_EV,
		S_FREE_CLR,
		S_MERGE_CHK,
		S_MERGE_EV,
		S_MERGE_WR,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

@@ hdl/bba_ctrl.sv @@
// sequencer of the buddy block allocator: issues one datapath command a cycle
// depends on bba_pkg
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl import bba_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   req_valid,
	output logic        req_stall,
	input  wire flags_t flags,
	output cmd_t        cmd
);

	state_t state_q, state_d;
	res_t   res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			res_q   <= RES_OK_FREE;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		res_d     = res_q;
		cmd.op    = OP_NONE;
		cmd.res   = res_q;
		req_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				if (flags.clr_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.op = OP_CLR;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (flags.is_alloc) begin
					if (flags.len_zero || flags.m_big) begin
						res_d   = RES_NOFIT;
						state_d = S_RESP;
					end else begin
						state_d = S_ORDER;
					end
				end else if (flags.bidx_range) begin
					res_d   = RES_RANGE;
					state_d = S_RESP;
				end else begin
					state_d = S_WALK_RD;
				end
			end
			S_ORDER: begin
				if (flags.m_zero) begin
					state_d = S_SCAN_RD;
				end else begin
					cmd.op = OP_ORD_STEP;
				end
			end
			S_SCAN_RD: begin
				cmd.op  = OP_RD_CUR;
				state_d = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				cmd.op = OP_SCAN_EV;
				if (flags.scan_exact) begin
					state_d = S_SPLIT;
				end else if (flags.scan_last) begin
					if (flags.found_next) begin
						state_d = S_SPLIT;
					end else begin
						res_d   = RES_NOFIT;
						state_d = S_RESP;
					end
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SPLIT: begin
				if (flags.split_more) begin
					cmd.op = OP_SPLIT;
				end else begin
					cmd.op  = OP_ALLOC_WR;
					res_d   = RES_OK_ADDR;
					state_d = S_RESP;
				end
			end
			S_WALK_RD: begin
				cmd.op  = OP_RD_CUR;
				state_d = S_WALK_EV;
			end
			S_WALK_EV: begin
				cmd.op = OP_WALK_EV;
				if (flags.hit) begin
					if (flags.is_free) begin
						state_d = S_FREE_CLR;
					end else begin
						res_d   = RES_OK_ADDR;
						state_d = S_RESP;
					end
				end else if (flags.past || flags.scan_last) begin
					res_d   = RES_RANGE;
					state_d = S_RESP;
				end else begin
					state_d = S_WALK_RD;
				end
			end
			S_FREE_CLR: begin
				cmd.op  = OP_FREE_CLR;
				state_d = S_MERGE_CHK;
			end
			S_MERGE_CHK: begin
				if (flags.merge_stop) begin
					res_d   = RES_OK_FREE;
					state_d = S_RESP;
				end else begin
					cmd.op  = OP_RD_BUDDY;
					state_d = S_MERGE_EV;
				end
			end
			S_MERGE_EV: begin
				if (flags.merge_ok) begin
					cmd.op  = OP_MERGE_WR1;
					state_d = S_MERGE_WR;
				end else begin
					res_d   = RES_OK_FREE;
					state_d = S_RESP;
				end
			end
			S_MERGE_WR: begin
				cmd.op  = OP_MERGE_WR2;
				state_d = S_MERGE_CHK;
			end
			S_RESP: begin
				if (flags.out_free) begin
					cmd.op  = OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/bba_dp.sv @@
// datapath of the buddy block allocator: unit table, scan/split/merge registers,
// output register; depends on bba_pkg
`timescale 1ns / 1ps
`default_nettype none

module bba_dp import bba_pkg::*; #(
	parameter int NUM_UNITS  = NUM_UNITS_DEF,
	parameter int UNIT_SHIFT = UNIT_SHIFT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output flags_t           flags,
	input  wire req_t        req,
	input  wire logic [31:0] base_address,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output rsp_t             rsp
);

	localparam int IW = $clog2(NUM_UNITS);
	localparam int CW = IW + 1;
	localparam logic [15:0] NUM_VEC = 16'(NUM_UNITS);
	localparam logic [CW-1:0] NUM_C = CW'(NUM_UNITS);

	// table entry: {allocated, order}
	logic [4:0] mem [NUM_UNITS];
	logic [4:0] rd_q;

	logic [1:0]    mode_q;
	logic [31:0]   len_q;
	logic [7:0]    bidx_q;
	logic [31:0]   m_q;
	logic [3:0]    want_q;
	logic [CW-1:0] cur_q;
	logic [IW-1:0] best_q;
	logic [3:0]    besto_q;
	logic          found_q;
	logic [3:0]    o_q;
	logic [IW-1:0] ridx_q;
	logic [CW-1:0] clr_idx_q, clr_head_q;
	logic [3:0]    clr_bit_q;
	logic          out_valid_q;
	rsp_t          out_q;

	logic          rd_alloc;
	logic [3:0]    rd_ord;
	logic [CW-1:0] cur_next;
	logic          cand;
	logic [3:0]    besto_m1;
	logic [CW-1:0] split_buddy;
	logic [CW-1:0] merge_buddy;
	logic          we, re;
	logic [IW-1:0] waddr, raddr;
	logic [4:0]    wdata;
	logic [31:0]   len_m1;
	logic [IW+7:0] ridx_ext;
	logic [63:0]   off64;
	logic [5:0]    byte_sh;
	logic [31:0]   res_addr, res_bytes;

	assign rd_alloc    = rd_q[4];
	assign rd_ord      = rd_q[3:0];
	assign cur_next    = cur_q + (CW'(1) << rd_ord);
	assign cand        = !rd_alloc && (rd_ord >= want_q)
		&& ((rd_ord == want_q) || !found_q || (rd_ord < besto_q));
	assign besto_m1    = besto_q - 4'd1;
	assign split_buddy = {1'b0, best_q} ^ (CW'(1) << besto_m1);
	assign merge_buddy = cur_q ^ (CW'(1) << o_q);
	assign len_m1      = req.request_length - 32'd1;

	always_comb begin
		flags.clr_done   = clr_idx_q == NUM_C;
		flags.is_alloc   = mode_q == MODE_ALLOC;
		flags.is_free    = mode_q == MODE_FREE;
		flags.len_zero   = len_q == 32'd0;
		flags.m_big      = (m_q >> MAX_ORDER) != 32'd0;
		flags.m_zero     = m_q == 32'd0;
		flags.bidx_range = 16'(bidx_q) >= 16'(NUM_UNITS);
		flags.scan_exact = !rd_alloc && (rd_ord == want_q);
		flags.scan_last  = cur_next >= NUM_C;
		flags.found_next = found_q || cand;
		flags.hit        = 16'(cur_q) == 16'(bidx_q);
		flags.past       = 16'(cur_q) > 16'(bidx_q);
		flags.split_more = besto_q > want_q;
		// the merge ends at order IW or MAX_ORDER, or when the buddy lies at or above the pool size
		flags.merge_stop = (32'(o_q) >= MAX_ORDER) || (32'(o_q) >= IW)
			|| (merge_buddy >= NUM_C);
		flags.merge_ok   = !rd_alloc && (rd_ord == o_q);
		flags.out_free   = !out_valid_q || !rsp_stall;
	end

	// table port selection
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = cur_q[IW-1:0];
		raddr = cur_q[IW-1:0];
		wdata = 5'd0;
		unique case (cmd.op)
			OP_CLR: begin
				we    = 1'b1;
				waddr = clr_idx_q[IW-1:0];
				if (clr_idx_q == clr_head_q) begin
					we    = NUM_VEC[clr_bit_q];
					wdata = {1'b0, clr_bit_q};
				end
			end
			OP_RD_CUR: begin
				re = 1'b1;
			end
			OP_SPLIT: begin
				we    = split_buddy < NUM_C;
				waddr = split_buddy[IW-1:0];
				wdata = {1'b0, besto_m1};
			end
			OP_ALLOC_WR: begin
				we    = 1'b1;
				waddr = best_q;
				wdata = {1'b1, want_q};
			end
			OP_FREE_CLR: begin
				we    = 1'b1;
				wdata = {1'b0, o_q};
			end
			OP_RD_BUDDY: begin
				re    = 1'b1;
				raddr = merge_buddy[IW-1:0];
			end
			OP_MERGE_WR1: begin
				we    = 1'b1;
				waddr = merge_buddy[IW-1:0];
				wdata = {1'b0, o_q + 4'd1};
			end
			OP_MERGE_WR2: begin
				we    = 1'b1;
				wdata = {1'b0, o_q + 4'd1};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_head_q <= '0;
			clr_bit_q  <= 4'(IW);
		end else if (cmd.op == OP_CLR) begin
			if (clr_idx_q == clr_head_q) begin
				// falling powers of two of the pool size lay the reset blocks
				clr_bit_q <= clr_bit_q - 4'd1;
				if (NUM_VEC[clr_bit_q]) begin
					clr_head_q <= clr_head_q + (CW'(1) << clr_bit_q);
					clr_idx_q  <= clr_idx_q + CW'(1);
				end
			end else begin
				clr_idx_q <= clr_idx_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				mode_q  <= req.mode;
				len_q   <= req.request_length;
				bidx_q  <= req.block_index;
				m_q     <= len_m1 >> UNIT_SHIFT;
				want_q  <= 4'd0;
				cur_q   <= '0;
				found_q <= 1'b0;
			end
			OP_ORD_STEP: begin
				m_q    <= m_q >> 1;
				want_q <= want_q + 4'd1;
			end
			OP_SCAN_EV: begin
				if (cand) begin
					best_q  <= cur_q[IW-1:0];
					besto_q <= rd_ord;
					found_q <= 1'b1;
				end
				cur_q <= cur_next;
			end
			OP_SPLIT: begin
				besto_q <= besto_m1;
			end
			OP_ALLOC_WR: begin
				ridx_q <= best_q;
				o_q    <= want_q;
			end
			OP_WALK_EV: begin
				if (flags.hit) begin
					o_q    <= rd_ord;
					ridx_q <= cur_q[IW-1:0];
				end else begin
					cur_q <= cur_next;
				end
			end
			OP_MERGE_WR2: begin
				o_q <= o_q + 4'd1;
				if (merge_buddy < cur_q) begin
					cur_q <= merge_buddy;
				end
			end
			default: begin
				o_q <= o_q;
			end
		endcase
	end

	assign ridx_ext  = {8'd0, ridx_q};
	assign off64     = 64'(ridx_q) << UNIT_SHIFT;
	assign res_addr  = base_address + off64[31:0];
	assign byte_sh   = 6'(o_q) + 6'(UNIT_SHIFT);
	assign res_bytes = byte_sh[5] ? 32'd0 : (32'd1 << byte_sh[4:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_RESULT) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_RESULT) begin
			out_q.result_index  <= bidx_q;
			out_q.start_address <= 32'd0;
			out_q.block_bytes   <= 32'd0;
			unique case (cmd.res)
				RES_OK_ADDR: begin
					out_q.status        <= ST_OK;
					out_q.result_index  <= ridx_ext[7:0];
					out_q.start_address <= res_addr;
					out_q.block_bytes   <= res_bytes;
				end
				RES_OK_FREE: begin
					out_q.status <= ST_OK;
				end
				RES_NOFIT: begin
					out_q.status       <= ST_NOFIT;
					out_q.result_index <= 8'd0;
				end
				RES_RANGE: begin
					out_q.status <= ST_RANGE;
				end
				default: begin
					out_q.status <= ST_RANGE;
				end
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

`default_nettype wire

@@ hdl/buddy_block_allocator.sv @@
// top level of the buddy block allocator: configuration port and wiring
// depends on bba_pkg, bba_ctrl, bba_dp
`timescale 1ns / 1ps
`default_nettype none

// Buddy allocator over NUM_UNITS units of 2**UNIT_SHIFT bytes each. After reset
// the unit table is swept one entry a cycle, with req_stall high, pausing at
// each zero bit of NUM_UNITS from bit $clog2(NUM_UNITS) down to its lowest set
// bit; base_address writes are taken meanwhile. One request is worked at a time.
// Allocate works out the order, reads the block heads from unit 0 to an exact
// fit or the smallest larger free block, splits it down and marks it allocated;
// free and lookup walk the block heads from unit 0, and a free then merges with
// free buddies. The result sits in an output register, so the next request may
// be taken while it waits for the consumer.
module buddy_block_allocator import bba_pkg::*; #(
	parameter int NUM_UNITS  = NUM_UNITS_DEF,
	parameter int UNIT_SHIFT = UNIT_SHIFT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire req_t        req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output rsp_t             rsp
);

	logic [31:0] base_q;
	flags_t      flags;
	cmd_t        cmd;
	logic        unused_addr;

	assign pready      = 1'b1;
	assign prdata      = base_q;
	// single register; every paddr value reads and writes it
	assign unused_addr = paddr != REG_BASE_ADDR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 32'd0;
		end else if (psel && penable && pwrite && (unused_addr || !unused_addr)) begin
			base_q <= pwdata;
		end
	end

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.flags     (flags),
		.cmd       (cmd)
	);

	bba_dp #(
		.NUM_UNITS  (NUM_UNITS),
		.UNIT_SHIFT (UNIT_SHIFT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.flags        (flags),
		.req          (req),
		.base_address (base_q),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp)
	);

`ifndef SYNTH
	// one request in flight: taking a beat closes the input at once
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in flight");

	// a fresh result only appears at the end of a request's work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result produced while idle");

	// status code three is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_NOFIT
			|| rsp.status == ST_RANGE))
		else $error("bad status code");
`endif

endmodule

`default_nettype wire
